@@ rtl/compression_ratio_profile_control_defines.svh @@
// Assertion macros for the compression ratio profile controller.
// Used by the port checker; expects clk_i and rst_ni in the including scope.
`ifndef COMPRESSION_RATIO_PROFILE_CONTROL_DEFINES_SVH
`define COMPRESSION_RATIO_PROFILE_CONTROL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define CRPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CRPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/crpc_pkg.sv @@
// Shared types and constants for the compression ratio profile controller.
// No dependencies; used by every module of the block.
`default_nettype none

package crpc_pkg;

  // Profile count default and field widths
  localparam int NumProfiles = 8;
  localparam int SizeW       = 32;
  localparam int SumW        = 36;
  localparam int RawW        = 41;
  localparam int RatioW      = 16;
  localparam int RunW        = 16;
  localparam int ProfW       = 3;
  localparam int AddrW       = 5;
  localparam int DataW       = 32;

  // Register reset values
  localparam logic [12:0] WidthRst    = 13'd4096;
  localparam logic [11:0] HeightRst   = 12'd3072;
  localparam logic [6:0]  SubfrRst    = 7'd1;
  localparam logic [15:0] UpperRst    = 16'd1536;
  localparam logic [15:0] LowerRst    = 16'd1280;
  localparam logic [15:0] HoldRst     = 16'd32;
  localparam logic [15:0] RatioRst    = 16'd1280;

  // Register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_SUBFR  = 3'd2,
    REG_UPPER  = 3'd3,
    REG_LOWER  = 3'd4,
    REG_HOLD   = 3'd5
  } reg_e;

  typedef struct packed {
    logic [SizeW-1:0] stream_size;
    logic             frame_end;
  } in_t;

  typedef struct packed {
    logic [ProfW-1:0]  profile;
    logic [RatioW-1:0] ratio_q8;
    logic              stepped_up;
    logic              stepped_down;
  } out_t;

  typedef struct packed {
    logic [12:0] frame_width;
    logic [11:0] frame_height;
    logic [6:0]  subframes_per_frame;
    logic [15:0] upper_ratio;
    logic [15:0] lower_ratio;
    logic [15:0] hold_frames;
  } cfg_t;

  // Divider request and response
  typedef struct packed {
    logic            start;
    logic [RawW-1:0] dividend;
    logic [SumW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [RatioW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ rtl/crpc_regs.sv @@
// Configuration register file with an APB-style write/read port.
// Depends on crpc_pkg for the register index codes and the config struct.
`default_nettype none

module crpc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crpc_pkg::AddrW-1:0]  paddr,
  input  logic [crpc_pkg::DataW-1:0]  pwdata,
  output logic [crpc_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output crpc_pkg::cfg_t              cfg_o
);

  crpc_pkg::cfg_t cfg_q;
  crpc_pkg::reg_e reg_idx;
  logic           wr_en;

  assign reg_idx = crpc_pkg::reg_e'(paddr[4:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width         <= crpc_pkg::WidthRst;
      cfg_q.frame_height        <= crpc_pkg::HeightRst;
      cfg_q.subframes_per_frame <= crpc_pkg::SubfrRst;
      cfg_q.upper_ratio         <= crpc_pkg::UpperRst;
      cfg_q.lower_ratio         <= crpc_pkg::LowerRst;
      cfg_q.hold_frames         <= crpc_pkg::HoldRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        crpc_pkg::REG_WIDTH:  cfg_q.frame_width         <= pwdata[12:0];
        crpc_pkg::REG_HEIGHT: cfg_q.frame_height        <= pwdata[11:0];
        crpc_pkg::REG_SUBFR:  cfg_q.subframes_per_frame <= pwdata[6:0];
        crpc_pkg::REG_UPPER:  cfg_q.upper_ratio         <= pwdata[15:0];
        crpc_pkg::REG_LOWER:  cfg_q.lower_ratio         <= pwdata[15:0];
        crpc_pkg::REG_HOLD:   cfg_q.hold_frames         <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register, zero-extended
  always_comb begin
    unique case (reg_idx)
      crpc_pkg::REG_WIDTH:  prdata = 32'(cfg_q.frame_width);
      crpc_pkg::REG_HEIGHT: prdata = 32'(cfg_q.frame_height);
      crpc_pkg::REG_SUBFR:  prdata = 32'(cfg_q.subframes_per_frame);
      crpc_pkg::REG_UPPER:  prdata = 32'(cfg_q.upper_ratio);
      crpc_pkg::REG_LOWER:  prdata = 32'(cfg_q.lower_ratio);
      crpc_pkg::REG_HOLD:   prdata = 32'(cfg_q.hold_frames);
      default:              prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/crpc_div.sv @@
// Iterative restoring divider: raw size over summed size, saturated to 16 bits.
// One shared subtractor: a saturation check, then one quotient bit per cycle.
// Depends on crpc_pkg for widths and the request/response structs.
`default_nettype none

module crpc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  crpc_pkg::div_req_t req_i,
  output crpc_pkg::div_rsp_t rsp_o
);

  localparam int RemW = crpc_pkg::SumW;
  localparam int QW   = crpc_pkg::RatioW;
  localparam int CntW = $clog2(QW);
  localparam logic [CntW-1:0] CntLast = CntW'(QW - 1);

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_CHK,
    DV_BITS
  } dv_state_e;

  dv_state_e         state_q;
  logic [RemW-1:0]   rem_q;
  logic [QW-1:0]     low_q;
  logic [QW-1:0]     quo_q;
  logic [RemW-1:0]   dvs_q;
  logic [CntW-1:0]   cnt_q;
  logic              done_q;

  logic [RemW:0]     minuend;
  logic [RemW+1:0]   diff;
  logic              borrow;

  // Shared subtractor: whole partial remainder in the check, shifted one in the bit steps
  assign minuend = (state_q == DV_CHK) ? {1'b0, rem_q} : {rem_q, low_q[QW-1]};
  assign diff    = {1'b0, minuend} - {2'b00, dvs_q};
  assign borrow  = diff[RemW+1];

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  // Sequence the check and the quotient bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      rem_q   <= '0;
      low_q   <= '0;
      quo_q   <= '0;
      dvs_q   <= '0;
    end else begin
      unique case (state_q)
        DV_IDLE: begin
          done_q <= 1'b0;
          if (req_i.start) begin
            rem_q   <= RemW'(req_i.dividend[crpc_pkg::RawW-1:QW]);
            low_q   <= req_i.dividend[QW-1:0];
            dvs_q   <= req_i.divisor;
            state_q <= DV_CHK;
          end
        end
        DV_CHK: begin
          // Upper part not below the divisor: quotient exceeds 16 bits
          done_q <= ~borrow;
          if (!borrow) begin
            quo_q   <= '1;
            state_q <= DV_IDLE;
          end else begin
            quo_q   <= '0;
            cnt_q   <= '0;
            state_q <= DV_BITS;
          end
        end
        DV_BITS: begin
          rem_q  <= borrow ? minuend[RemW-1:0] : diff[RemW-1:0];
          low_q  <= {low_q[QW-2:0], 1'b0};
          quo_q  <= {quo_q[QW-2:0], ~borrow};
          cnt_q  <= cnt_q + 1'b1;
          done_q <= (cnt_q == CntLast);
          if (cnt_q == CntLast) begin
            state_q <= DV_IDLE;
          end
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= DV_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/compression_ratio_profile_control.sv @@
// Compression ratio profile controller, top level.
// Depends on crpc_pkg, crpc_regs and crpc_div.
`default_nettype none

// Codestream sizes enter one per request and add into a 36-bit saturating sum;
// a size that does not end the frame is accepted without a stall and gives no
// result. The request that ends the frame stalls the input until its result is
// loaded: two multiply steps and a scale form width*height*subframes*320, a
// start state launches the restoring divider, which runs a check step and then
// 16 bit steps on raw/sum (only the check when the quotient saturates, no
// divider at all when the sum is zero), then the smoothed ratio, run counters
// and profile are updated in turn (the ratio is kept when the sum is zero). One
// result request leaves per frame; the output register holds it until taken and
// a finished frame waits for that register before it loads its result.
module compression_ratio_profile_control #(
  parameter int NUM_PROFILES = crpc_pkg::NumProfiles
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  crpc_pkg::in_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output crpc_pkg::out_t             out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [crpc_pkg::AddrW-1:0] paddr,
  input  logic [crpc_pkg::DataW-1:0] pwdata,
  output logic [crpc_pkg::DataW-1:0] prdata,
  output logic                       pready
);

  localparam int SumW   = crpc_pkg::SumW;
  localparam int RawW   = crpc_pkg::RawW;
  localparam int RatioW = crpc_pkg::RatioW;
  localparam int RunW   = crpc_pkg::RunW;
  localparam int ProfW  = crpc_pkg::ProfW;
  localparam logic [ProfW-1:0] ProfMax = ProfW'(NUM_PROFILES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_SCALE,
    ST_DIVGO,
    ST_DIV,
    ST_RUN,
    ST_STEP
  } state_e;

  state_e               state_q;
  logic [SumW-1:0]      size_sum_q;
  logic [RatioW-1:0]    ratio_q;
  logic [ProfW-1:0]     profile_q;
  logic [RunW-1:0]      over_run_q;
  logic [RunW-1:0]      under_run_q;
  logic                 out_valid_q;
  crpc_pkg::out_t       out_data_q;
  logic [31:0]          prod_q;
  logic [RawW-1:0]      raw_q;

  crpc_pkg::cfg_t       cfg;
  crpc_pkg::div_req_t   div_req;
  crpc_pkg::div_rsp_t   div_rsp;

  logic                 in_acc;
  logic [SumW:0]        sum_ext;
  logic [SumW-1:0]      sum_sat;
  logic [RatioW+2:0]    smooth;
  logic [RunW-1:0]      over_inc;
  logic [RunW-1:0]      under_inc;
  logic                 step_up;
  logic                 step_down;
  logic [ProfW-1:0]     prof_mid;
  logic                 out_free;
  logic                 load_out;

  crpc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign div_req.start    = (state_q == ST_DIVGO);
  assign div_req.dividend = raw_q;
  assign div_req.divisor  = size_sum_q;

  crpc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign load_out    = (state_q == ST_STEP) && out_free;

  // Saturating size accumulation
  assign sum_ext = (SumW+1)'(size_sum_q) + (SumW+1)'(in_data_i.stream_size);
  assign sum_sat = sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];

  // 7/8 old + 1/8 new, floored
  assign smooth = {ratio_q, 3'b000} - (RatioW+3)'(ratio_q) + (RatioW+3)'(div_rsp.quotient);

  // Saturating run increments
  assign over_inc  = (over_run_q == '1) ? over_run_q : over_run_q + 1'b1;
  assign under_inc = (under_run_q == '1) ? under_run_q : under_run_q + 1'b1;

  // Up-step first, then down-step against the possibly raised profile
  assign step_up   = (over_run_q > cfg.hold_frames) && (profile_q < ProfMax);
  assign prof_mid  = profile_q + ProfW'(step_up);
  assign step_down = (under_run_q > cfg.hold_frames) && (prof_mid != '0);

  // Raw frame size datapath: width*height, times subframes, times 320
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL1) begin
      prod_q <= 32'(cfg.frame_width) * 32'(cfg.frame_height);
    end else if (state_q == ST_MUL2) begin
      prod_q <= 32'(prod_q[24:0]) * 32'(cfg.subframes_per_frame);
    end
    if (state_q == ST_SCALE) begin
      raw_q <= RawW'({prod_q, 8'b0}) + RawW'({prod_q, 6'b0});
    end
  end

  // Sequencer, tracker state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_sum_q  <= '0;
      ratio_q     <= crpc_pkg::RatioRst;
      profile_q   <= ProfMax;
      over_run_q  <= '0;
      under_run_q <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // Raise the result when a frame finishes, drop it once taken
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            size_sum_q <= sum_sat;
            if (in_data_i.frame_end) begin
              state_q <= ST_MUL1;
            end
          end
        end
        ST_MUL1:  state_q <= ST_MUL2;
        ST_MUL2:  state_q <= ST_SCALE;
        ST_SCALE: state_q <= (size_sum_q != '0) ? ST_DIVGO : ST_RUN;
        ST_DIVGO: state_q <= ST_DIV;
        ST_DIV: begin
          if (div_rsp.done) begin
            ratio_q <= smooth[RatioW+2:3];
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          over_run_q  <= (ratio_q > cfg.upper_ratio) ? over_inc : '0;
          under_run_q <= (ratio_q < cfg.lower_ratio) ? under_inc : '0;
          state_q     <= ST_STEP;
        end
        ST_STEP: begin
          // Hold until the output register is free
          if (load_out) begin
            profile_q  <= prof_mid - ProfW'(step_down);
            size_sum_q <= '0;
            if (step_up) begin
              over_run_q <= '0;
            end
            if (step_down) begin
              under_run_q <= '0;
            end
            out_data_q.profile      <= prof_mid - ProfW'(step_down);
            out_data_q.ratio_q8     <= ratio_q;
            out_data_q.stepped_up   <= step_up;
            out_data_q.stepped_down <= step_down;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/crpc_checker.sv @@
// Port-level checker for the compression ratio profile controller, and its bind.
// Depends on crpc_pkg and compression_ratio_profile_control_defines.svh.
`default_nettype none

`include "compression_ratio_profile_control_defines.svh"

module crpc_checker #(
  parameter int NUM_PROFILES = crpc_pkg::NumProfiles
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input crpc_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input crpc_pkg::out_t out_data_o
);

  // A stalled result holds
  `CRPC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "result changed while stalled")

  // The frame end request starts the ratio update, so the input stalls next
  `CRPC_ASSERT_NEXT(a_busy_after_end, in_valid_i && !in_stall_o && in_data_i.frame_end, in_stall_o, "input not stalled after frame end")

  // Profile stays within the configured count
  `CRPC_ASSERT_IMPL(a_prof_bound, out_valid_o, out_data_o.profile <= 3'(NUM_PROFILES - 1), "profile out of range")

  // A lone up-step cannot leave the lowest profile
  `CRPC_ASSERT_IMPL(a_up_nonzero, out_valid_o && out_data_o.stepped_up && !out_data_o.stepped_down, out_data_o.profile != 3'd0, "up-step reported at profile zero")

endmodule

bind compression_ratio_profile_control crpc_checker #(
  .NUM_PROFILES (NUM_PROFILES)
) u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
